/* design/fotr_pkg.sv */
// shared types, constants and index helpers for the fourth-order tensor rotation core
`timescale 1ns / 1ps
`default_nettype none

package fotr_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD_ROT   = 2'd0;
  localparam logic [1:0] KIND_LOAD_STIFF = 2'd1;
  localparam logic [1:0] KIND_READ       = 2'd2;

  localparam logic [6:0] ROT_ENTRIES = 7'd9;
  localparam logic [6:0] TEN_ENTRIES = 7'd81;
  localparam logic [6:0] TERM_LAST   = 7'd80;
  localparam logic [2:0] FETCH_LAST  = 3'd4;

  localparam logic signed [31:0] ROT_MAX = 32'sd131071;
  localparam logic signed [31:0] ROT_MIN = -32'sd131072;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam int unsigned RotW = 18;
  localparam int unsigned AccW = 44;

  // one rotation row: three Q1.16 entries
  typedef logic [2:0][RotW-1:0] rot_row_t;

  typedef struct packed {
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic [1:0] l;
  } tidx_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
  } ridx_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] s;
    logic [1:0] t;
  } mac_issue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } fotr_state_e;

  // base-3 digits of a tensor index (0..80) by compare and subtract
  function automatic tidx_t split_tidx(input logic [6:0] idx);
    tidx_t      d;
    logic [6:0] r;
    r = idx;
    if (r >= 7'd54) begin
      d.i = 2'd2;
      r   = r - 7'd54;
    end else if (r >= 7'd27) begin
      d.i = 2'd1;
      r   = r - 7'd27;
    end else begin
      d.i = 2'd0;
    end
    if (r >= 7'd18) begin
      d.j = 2'd2;
      r   = r - 7'd18;
    end else if (r >= 7'd9) begin
      d.j = 2'd1;
      r   = r - 7'd9;
    end else begin
      d.j = 2'd0;
    end
    if (r >= 7'd6) begin
      d.k = 2'd2;
      r   = r - 7'd6;
    end else if (r >= 7'd3) begin
      d.k = 2'd1;
      r   = r - 7'd3;
    end else begin
      d.k = 2'd0;
    end
    d.l = r[1:0];
    return d;
  endfunction

  // row and column of a rotation index (0..8)
  function automatic ridx_t split_ridx(input logic [3:0] idx);
    ridx_t      d;
    logic [3:0] r;
    r = idx;
    if (r >= 4'd6) begin
      d.row = 2'd2;
      r     = r - 4'd6;
    end else if (r >= 4'd3) begin
      d.row = 2'd1;
      r     = r - 4'd3;
    end else begin
      d.row = 2'd0;
    end
    d.col = r[1:0];
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/fotr_mac.sv */
// four-multiply product pipeline and wide accumulator, one term per cycle
`timescale 1ns / 1ps
`default_nettype none

module fotr_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   clear_i,
  input  fotr_pkg::mac_issue_t                   issue_i,
  input  logic signed [fotr_pkg::RotW-1:0]       rot_m_i,
  input  logic signed [fotr_pkg::RotW-1:0]       rot_n_i,
  input  fotr_pkg::rot_row_t                     row_k_i,
  input  fotr_pkg::rot_row_t                     row_l_i,
  input  logic signed [31:0]                     stiff_i,
  output logic signed [fotr_pkg::AccW-1:0]       acc_o,
  output logic                                   busy_o
);

  // stage 1: r(i,m) * r(j,n)
  logic signed [35:0] prod1;
  logic signed [19:0] p1_q;
  logic [1:0]         s1_q, t1_q;
  logic               v1_q;

  // stage 2: * r(k,s), stiffness word arrives alongside
  logic signed [17:0] rot_k;
  logic signed [37:0] prod2;
  logic signed [21:0] p2_q;
  logic [1:0]         t2_q;
  logic signed [31:0] c2_q;
  logic               v2_q;

  // stage 3: * r(l,t)
  logic signed [17:0] rot_l;
  logic signed [39:0] prod3;
  logic signed [23:0] p3_q;
  logic signed [31:0] c3_q;
  logic               v3_q;

  // stage 4: * stiffness
  logic signed [55:0] prod4;
  logic signed [39:0] p4_q;
  logic               v4_q;

  logic signed [fotr_pkg::AccW-1:0] acc_q;

  // products are floored by dropping 16 low bits; p1-p3 keep 16 fraction bits
  assign prod1 = rot_m_i * rot_n_i;
  assign rot_k = $signed(row_k_i[s1_q]);
  assign prod2 = p1_q * rot_k;
  assign rot_l = $signed(row_l_i[t2_q]);
  assign prod3 = p2_q * rot_l;
  assign prod4 = p3_q * c3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= issue_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (clear_i) begin
        acc_q <= '0;
      end else if (v4_q) begin
        acc_q <= acc_q + fotr_pkg::AccW'(p4_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= prod1[35:16];
    s1_q <= issue_i.s;
    t1_q <= issue_i.t;
    p2_q <= prod2[37:16];
    t2_q <= t1_q;
    c2_q <= stiff_i;
    p3_q <= prod3[39:16];
    c3_q <= c2_q;
    p4_q <= prod4[55:16];
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | v2_q | v3_q | v4_q;

endmodule

`default_nettype wire

/* design/fourth_order_tensor_rotation_core.sv */
// top level: rotation and stiffness stores, read sequencer and saturating output register
//
// fourth-order tensor rotation core
// one valid/ready input channel carries kind, index and value; one valid/ready
// output channel carries rotated_value and overflow.
// kind 0 writes a rotation entry (3r+c, clamped to 18 bits), kind 1 writes a
// stiffness entry (27i+9j+3k+l); both complete in the transfer cycle and give
// no result. out-of-range load indexes and kind 3 are dropped.
// kind 2 asks for one rotated entry: four rotation rows are fetched from the
// row-wide rotation memory, then the 81 terms stream one a cycle out of the
// stiffness memory through a four-stage multiply pipeline into a 44-bit
// accumulator, and the sum is saturated to 32 bits.
// a read holds off further input until its result is in the output register,
// so loads go one a cycle only while no read is running; the one stiffness memory
// port and the single product pipeline set the pace of reads.
// a read with an index above 80 returns zero without the row fetch or the terms.
// input is taken only while the sequencer is idle, and a result waiting in the
// output register does not hold off further transfers; a stalled receiver only
// delays the finishing step of the next read.
// reset clears control state; both stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fourth_order_tensor_rotation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [6:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rotated_value_o,
  output logic               overflow_o
);

  fotr_pkg::fotr_state_e state_q, state_d;

  logic in_fire;
  logic start_read;
  logic out_load;

  // stores
  fotr_pkg::rot_row_t rot_mem_q [3];
  logic signed [31:0] ten_mem_q [81];
  fotr_pkg::rot_row_t rot_rd_q;
  logic signed [31:0] ten_rd_q;
  logic [1:0]         rot_raddr;

  // load path
  fotr_pkg::ridx_t                rsel;
  logic signed [fotr_pkg::RotW-1:0] rot_clamped;

  // read sequencing
  fotr_pkg::tidx_t    dig_q;
  logic               bad_q;
  logic [2:0]         fetch_cnt_q;
  logic [6:0]         term_cnt_q;
  logic [1:0]         m_q, n_q, s_q, t_q;
  fotr_pkg::rot_row_t rows_q [4];

  fotr_pkg::mac_issue_t             issue;
  logic signed [fotr_pkg::AccW-1:0] acc;
  logic                             mac_busy;

  // result
  logic               sat_ovf;
  logic signed [31:0] sat_value;
  logic               out_valid_q;
  logic signed [31:0] rotated_value_q;
  logic               overflow_q;

  assign in_ready_o = (state_q == fotr_pkg::ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign start_read = in_fire && (kind_i == fotr_pkg::KIND_READ);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fotr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      fotr_pkg::ST_IDLE: begin
        if (start_read) begin
          state_d = (index_i < fotr_pkg::TEN_ENTRIES) ? fotr_pkg::ST_FETCH
                                                      : fotr_pkg::ST_FINISH;
        end
      end
      fotr_pkg::ST_FETCH: begin
        if (fetch_cnt_q == fotr_pkg::FETCH_LAST) begin
          state_d = fotr_pkg::ST_RUN;
        end
      end
      fotr_pkg::ST_RUN: begin
        if (term_cnt_q == fotr_pkg::TERM_LAST) begin
          state_d = fotr_pkg::ST_DRAIN;
        end
      end
      fotr_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = fotr_pkg::ST_FINISH;
        end
      end
      fotr_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fotr_pkg::ST_IDLE;
        end
      end
      default: state_d = fotr_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- loads
  assign rsel = fotr_pkg::split_ridx(index_i[3:0]);

  always_comb begin
    if (value_i > fotr_pkg::ROT_MAX) begin
      rot_clamped = fotr_pkg::ROT_MAX[fotr_pkg::RotW-1:0];
    end else if (value_i < fotr_pkg::ROT_MIN) begin
      rot_clamped = fotr_pkg::ROT_MIN[fotr_pkg::RotW-1:0];
    end else begin
      rot_clamped = value_i[fotr_pkg::RotW-1:0];
    end
  end

  always_comb begin
    case (fetch_cnt_q[1:0])
      2'd0:    rot_raddr = dig_q.i;
      2'd1:    rot_raddr = dig_q.j;
      2'd2:    rot_raddr = dig_q.k;
      default: rot_raddr = dig_q.l;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i == fotr_pkg::KIND_LOAD_ROT && index_i < fotr_pkg::ROT_ENTRIES) begin
      rot_mem_q[rsel.row][rsel.col] <= rot_clamped;
    end
    rot_rd_q <= rot_mem_q[rot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i == fotr_pkg::KIND_LOAD_STIFF && index_i < fotr_pkg::TEN_ENTRIES) begin
      ten_mem_q[index_i] <= value_i;
    end
    ten_rd_q <= ten_mem_q[term_cnt_q];
  end

  // ---------------------------------------------------------------- read sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_cnt_q <= '0;
      term_cnt_q  <= '0;
      m_q         <= '0;
      n_q         <= '0;
      s_q         <= '0;
      t_q         <= '0;
      bad_q       <= 1'b0;
    end else begin
      if (start_read) begin
        fetch_cnt_q <= '0;
        term_cnt_q  <= '0;
        m_q         <= '0;
        n_q         <= '0;
        s_q         <= '0;
        t_q         <= '0;
        bad_q       <= !(index_i < fotr_pkg::TEN_ENTRIES);
      end else if (state_q == fotr_pkg::ST_FETCH) begin
        fetch_cnt_q <= fetch_cnt_q + 3'd1;
      end else if (state_q == fotr_pkg::ST_RUN) begin
        term_cnt_q <= term_cnt_q + 7'd1;
        // base-3 walk over m, n, s, t in step with the flat stiffness address
        if (t_q == 2'd2) begin
          t_q <= 2'd0;
          if (s_q == 2'd2) begin
            s_q <= 2'd0;
            if (n_q == 2'd2) begin
              n_q <= 2'd0;
              m_q <= m_q + 2'd1;
            end else begin
              n_q <= n_q + 2'd1;
            end
          end else begin
            s_q <= s_q + 2'd1;
          end
        end else begin
          t_q <= t_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_read) begin
      dig_q <= fotr_pkg::split_tidx(index_i);
    end
    // row data returns in the cycle after its address
    if (state_q == fotr_pkg::ST_FETCH && fetch_cnt_q != 3'd0) begin
      rows_q[2'(fetch_cnt_q - 3'd1)] <= rot_rd_q;
    end
  end

  assign issue.valid = (state_q == fotr_pkg::ST_RUN);
  assign issue.s     = s_q;
  assign issue.t     = t_q;

  fotr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (start_read),
    .issue_i (issue),
    .rot_m_i ($signed(rows_q[0][m_q])),
    .rot_n_i ($signed(rows_q[1][n_q])),
    .row_k_i (rows_q[2]),
    .row_l_i (rows_q[3]),
    .stiff_i (ten_rd_q),
    .acc_o   (acc),
    .busy_o  (mac_busy)
  );

  // ---------------------------------------------------------------- result
  // sum fits 32 bits only if the top bits are all copies of bit 31
  assign sat_ovf = !((&acc[fotr_pkg::AccW-1:31]) || !(|acc[fotr_pkg::AccW-1:31]));

  always_comb begin
    if (sat_ovf) begin
      sat_value = acc[fotr_pkg::AccW-1] ? fotr_pkg::SAT_MIN : fotr_pkg::SAT_MAX;
    end else begin
      sat_value = acc[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rotated_value_q <= bad_q ? 32'sd0 : sat_value;
      overflow_q      <= bad_q ? 1'b0 : sat_ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rotated_value_o = rotated_value_q;
  assign overflow_o      = overflow_q;

  // ---------------------------------------------------------------- assertions
  a_read_starts_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_read && index_i < fotr_pkg::TEN_ENTRIES) |=> (state_q == fotr_pkg::ST_FETCH))
    else $error("in-range read did not start the row fetch");

  a_mac_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fotr_pkg::ST_IDLE) |-> !mac_busy)
    else $error("product pipeline busy while idle");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fotr_pkg::ST_FINISH && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && state_q == fotr_pkg::ST_IDLE))
    else $error("finished read not placed in output register");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && overflow_q)
      |-> (rotated_value_q == fotr_pkg::SAT_MAX || rotated_value_q == fotr_pkg::SAT_MIN))
    else $error("overflow flagged without a saturated value");

endmodule

`default_nettype wire
